/* sv/assert_macros.svh */
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define BLI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// plain condition checked at every rising edge outside reset
`define BLI_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: condition failed");

`endif

/* sv/bli_pkg.sv */
// shared types and constants of the bilinear interpolation core
package bli_pkg;

    // command codes of an input word
    typedef enum logic [2:0] {
        CMD_AXIS1   = 3'd0,
        CMD_AXIS2   = 3'd1,
        CMD_TABLE_A = 3'd2,
        CMD_TABLE_B = 3'd3,
        CMD_QUERY   = 3'd4
    } cmd_t;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 8;
    localparam int VAL_W     = 17;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int CNT_W     = 5;
    localparam int TAB_DEPTH = 256;
    localparam int TAB_AW    = 8;
    localparam int T_W       = 18;
    localparam logic [OUT_W-1:0] Q15_ONE = 16'd32768;

    // point count registers
    typedef struct packed {
        logic [CNT_W-1:0] eps_points;
        logic [CNT_W-1:0] theta_points;
    } cfg_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        B_IDLE,
        B_RD0,
        B_RDL,
        B_CLAMP,
        B_SRCH,
        B_FRAC,
        B_DIV,
        B_IDX,
        B_TRD,
        B_MAC,
        B_OUT
    } bstate_t;

endpackage

/* sv/bli_ram.sv */
// generic one write port, one registered read port ram
module bli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bli_front.sv */
// input side: decodes commands, saturates coordinates, drops void words
module bli_front #(
    parameter int MAX_AXIS1_POINTS = 16,
    parameter int MAX_AXIS2_POINTS = 16,
    parameter int COORD_BITS       = 16,
    parameter int ITEM_W           = 28 + 2 * 16
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,
    input  logic              q_full,
    output logic              q_push,
    output logic [ITEM_W-1:0] q_item
);

    localparam int SW = 34;
    localparam logic [SW-1:0] CMAX = (SW'(1) << COORD_BITS) - SW'(1);

    logic [bli_pkg::CMD_W-1:0] cmd;
    logic [bli_pkg::IDX_W-1:0] idx;
    logic [bli_pkg::VAL_W-1:0] val;
    logic [bli_pkg::IN_W-1:0]  eps_in;
    logic [bli_pkg::IN_W-1:0]  theta_in;
    logic [COORD_BITS-1:0]     ce;
    logic [COORD_BITS-1:0]     ct;
    logic                      keep;

    // saturate a signed value to the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic [COORD_BITS-1:0] r;
        if (v < 0)
            r = '0;
        else if ($unsigned(v) > CMAX)
            r = CMAX[COORD_BITS-1:0];
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

    // field unpacking
    assign cmd      = s_tdata[2:0];
    assign idx      = s_tdata[10:3];
    assign val      = s_tdata[27:11];
    assign eps_in   = s_tdata[43:28];
    assign theta_in = s_tdata[59:44];

    // axis loads carry the saturated value in the first coordinate slot
    always_comb
    begin
        keep = 1'b0;
        ce   = sat_coord(SW'($signed(val)));
        ct   = sat_coord($signed({{(SW-bli_pkg::IN_W){1'b0}}, theta_in}));
        case (bli_pkg::cmd_t'(cmd))
            bli_pkg::CMD_AXIS1:
                keep = ({1'b0, idx} < 9'(MAX_AXIS1_POINTS));
            bli_pkg::CMD_AXIS2:
                keep = ({1'b0, idx} < 9'(MAX_AXIS2_POINTS));
            bli_pkg::CMD_TABLE_A,
            bli_pkg::CMD_TABLE_B:
                keep = 1'b1;
            bli_pkg::CMD_QUERY:
            begin
                keep = 1'b1;
                ce   = sat_coord($signed({{(SW-bli_pkg::IN_W){1'b0}}, eps_in}));
            end
            default:
                keep = 1'b0;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;
    assign q_item   = {ct, ce, val, idx, cmd};

endmodule

/* sv/bli_queue.sv */
// two entry queue between front and back
module bli_queue #(
    parameter int W = 60
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data
);

    logic [W-1:0] slot_reg [2];
    logic         wptr_reg;
    logic         wptr_next;
    logic         rptr_reg;
    logic         rptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rptr_reg];

endmodule

/* sv/bli_back.sv */
// back end: table writes, axis search, serial divide and blend sequencer
module bli_back #(
    parameter int MAX_AXIS1_POINTS = 16,
    parameter int MAX_AXIS2_POINTS = 16,
    parameter int COORD_BITS       = 16,
    parameter int FRAC_BITS        = 15,
    parameter int ITEM_W           = 28 + 2 * 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bli_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  logic [ITEM_W-1:0] q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata
);

    localparam int C    = COORD_BITS;
    localparam int A1W  = $clog2(MAX_AXIS1_POINTS);
    localparam int A2W  = $clog2(MAX_AXIS2_POINTS);
    localparam int IW0  = (A1W > A2W) ? A1W : A2W;
    localparam int IW   = (IW0 > 5) ? IW0 : 5;
    localparam int FW   = FRAC_BITS + 1;
    localparam int DCW  = $clog2(FRAC_BITS + 1);
    localparam int PW   = bli_pkg::T_W + FW + 1;
    localparam int AW   = PW + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
    localparam int VO   = bli_pkg::CMD_W + bli_pkg::IDX_W;
    localparam int CEO  = VO + bli_pkg::VAL_W;
    localparam int CTO  = CEO + C;

    // queue head fields
    logic [bli_pkg::CMD_W-1:0] h_cmd;
    logic [bli_pkg::IDX_W-1:0] h_idx;
    logic [bli_pkg::VAL_W-1:0] h_val;
    logic [C-1:0]              h_ce;
    logic [C-1:0]              h_ct;

    assign h_cmd = q_item[bli_pkg::CMD_W-1:0];
    assign h_idx = q_item[VO-1:bli_pkg::CMD_W];
    assign h_val = q_item[CEO-1:VO];
    assign h_ce  = q_item[CTO-1:CEO];
    assign h_ct  = q_item[CTO+C-1:CTO];

    // sequencer registers
    bli_pkg::bstate_t state_reg, state_next;
    logic                 ax_reg, ax_next;
    logic [C-1:0]         ce_reg, ce_next;
    logic [C-1:0]         ct_reg, ct_next;
    logic [C-1:0]         c_reg, c_next;
    logic [C-1:0]         g0_reg, g0_next;
    logic [C-1:0]         lo_reg, lo_next;
    logic [C-1:0]         hi_reg, hi_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        ie_reg, ie_next;
    logic [IW-1:0]        it_reg, it_next;
    logic [FW-1:0]        fe_reg, fe_next;
    logic [FW-1:0]        ft_reg, ft_next;
    logic [C:0]           rem_reg, rem_next;
    logic [C:0]           ad_reg, ad_next;
    logic [FW-1:0]        quo_reg, quo_next;
    logic [DCW-1:0]       dcnt_reg, dcnt_next;
    logic [bli_pkg::TAB_AW-1:0] base_reg, base_next;
    logic [1:0]           k_reg, k_next;
    logic [2:0]           p_reg, p_next;
    logic                 sub_reg, sub_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [bli_pkg::T_W-1:0] va_reg [4];
    logic signed [bli_pkg::T_W-1:0] va_next [4];
    logic signed [bli_pkg::T_W-1:0] vb_reg [4];
    logic signed [bli_pkg::T_W-1:0] vb_next [4];
    logic signed [bli_pkg::T_W-1:0] t_reg [4];
    logic signed [bli_pkg::T_W-1:0] t_next [4];
    logic [bli_pkg::OUT_W-1:0] ra_reg, ra_next;
    logic [bli_pkg::OUT_W-1:0] rb_reg, rb_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg, out_data_next;

    // memory ports
    logic                       a1_we, a2_we, ta_we, tb_we;
    logic [IW-1:0]              ax_raddr;
    logic [C-1:0]               a1_rd, a2_rd, g_rd;
    logic [bli_pkg::TAB_AW-1:0] tab_raddr;
    logic [bli_pkg::VAL_W-1:0]  ta_rd, tb_rd;

    // saturated point counts
    logic [8:0]    ne_w, nt_w;
    logic [IW-1:0] ne, nt, n_cur;

    // clamp a blend result to [0, one] in q1.15
    function automatic logic [bli_pkg::OUT_W-1:0] clamp_q15(
        input logic signed [bli_pkg::T_W-1:0] v);
        logic [bli_pkg::OUT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if ($unsigned(v) > {2'b00, bli_pkg::Q15_ONE})
            r = bli_pkg::Q15_ONE;
        else
            r = v[bli_pkg::OUT_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        ne_w = {4'b0, cfg.eps_points};
        if (cfg.eps_points < 5'd2)
            ne_w = 9'd2;
        else if ({4'b0, cfg.eps_points} > 9'(MAX_AXIS1_POINTS))
            ne_w = 9'(MAX_AXIS1_POINTS);
        nt_w = {4'b0, cfg.theta_points};
        if (cfg.theta_points < 5'd2)
            nt_w = 9'd2;
        else if ({4'b0, cfg.theta_points} > 9'(MAX_AXIS2_POINTS))
            nt_w = 9'(MAX_AXIS2_POINTS);
    end

    assign ne    = IW'(ne_w);
    assign nt    = IW'(nt_w);
    assign n_cur = ax_reg ? nt : ne;
    assign g_rd  = ax_reg ? a2_rd : a1_rd;

    // grid axes and value tables
    bli_ram #(.WIDTH(C), .DEPTH(MAX_AXIS1_POINTS)) u_axis1 (
        .clk   (clk),
        .we    (a1_we),
        .waddr (h_idx[A1W-1:0]),
        .wdata (h_ce),
        .raddr (ax_raddr[A1W-1:0]),
        .rdata (a1_rd)
    );

    bli_ram #(.WIDTH(C), .DEPTH(MAX_AXIS2_POINTS)) u_axis2 (
        .clk   (clk),
        .we    (a2_we),
        .waddr (h_idx[A2W-1:0]),
        .wdata (h_ce),
        .raddr (ax_raddr[A2W-1:0]),
        .rdata (a2_rd)
    );

    bli_ram #(.WIDTH(bli_pkg::VAL_W), .DEPTH(bli_pkg::TAB_DEPTH)) u_table_a (
        .clk   (clk),
        .we    (ta_we),
        .waddr (h_idx),
        .wdata (h_val),
        .raddr (tab_raddr),
        .rdata (ta_rd)
    );

    bli_ram #(.WIDTH(bli_pkg::VAL_W), .DEPTH(bli_pkg::TAB_DEPTH)) u_table_b (
        .clk   (clk),
        .we    (tb_we),
        .waddr (h_idx),
        .wdata (h_val),
        .raddr (tab_raddr),
        .rdata (tb_rd)
    );

    // next state and datapath
    always_comb
    begin
        logic [C-1:0]   c1;
        logic signed [C+1:0] num, den;
        logic [C:0]     an, adv;
        logic [C+1:0]   rem2;
        logic           qbit;
        logic           fin;
        logic [FW-1:0]  f_fin;
        logic [2*IW-1:0] rowp;
        logic [bli_pkg::TAB_AW-1:0] base;
        logic [1:0]     kn;
        logic signed [bli_pkg::T_W-1:0] opa;
        logic [FW-1:0]  fsel, wgt;
        logic signed [PW-1:0] prod;
        logic signed [AW-1:0] sum;
        logic signed [bli_pkg::T_W-1:0] res;

        state_next     = state_reg;
        ax_next        = ax_reg;
        ce_next        = ce_reg;
        ct_next        = ct_reg;
        c_next         = c_reg;
        g0_next        = g0_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        ie_next        = ie_reg;
        it_next        = it_reg;
        fe_next        = fe_reg;
        ft_next        = ft_reg;
        rem_next       = rem_reg;
        ad_next        = ad_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        sub_next       = sub_reg;
        acc_next       = acc_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        t_next         = t_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        a1_we          = 1'b0;
        a2_we          = 1'b0;
        ta_we          = 1'b0;
        tb_we          = 1'b0;
        ax_raddr       = i_reg;
        tab_raddr      = base_reg;
        fin            = 1'b0;
        f_fin          = '0;
        c1             = c_reg;
        num            = '0;
        den            = '0;
        an             = '0;
        adv            = '0;
        rem2           = '0;
        qbit           = 1'b0;
        rowp           = '0;
        base           = '0;
        kn             = k_reg + 2'd1;
        opa            = '0;
        fsel           = '0;
        wgt            = '0;
        prod           = '0;
        sum            = '0;
        res            = '0;

        case (state_reg)
            bli_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (bli_pkg::cmd_t'(h_cmd))
                        bli_pkg::CMD_AXIS1:   a1_we = 1'b1;
                        bli_pkg::CMD_AXIS2:   a2_we = 1'b1;
                        bli_pkg::CMD_TABLE_A: ta_we = 1'b1;
                        bli_pkg::CMD_TABLE_B: tb_we = 1'b1;
                        bli_pkg::CMD_QUERY:
                        begin
                            ce_next    = h_ce;
                            ct_next    = h_ct;
                            ax_next    = 1'b0;
                            state_next = bli_pkg::B_RD0;
                        end
                        default:
                            q_pop = 1'b1;
                    endcase
                end
            end

            bli_pkg::B_RD0:
            begin
                ax_raddr   = '0;
                state_next = bli_pkg::B_RDL;
            end

            bli_pkg::B_RDL:
            begin
                g0_next    = g_rd;
                ax_raddr   = n_cur - IW'(1);
                state_next = bli_pkg::B_CLAMP;
            end

            // clamp to first point, then to last point
            bli_pkg::B_CLAMP:
            begin
                c1 = ax_reg ? ct_reg : ce_reg;
                if (c1 < g0_reg)
                    c1 = g0_reg;
                if (c1 > g_rd)
                    c1 = g_rd;
                c_next     = c1;
                lo_next    = g0_reg;
                i_next     = '0;
                ax_raddr   = IW'(1);
                state_next = bli_pkg::B_SRCH;
            end

            // linear search, one point a cycle
            bli_pkg::B_SRCH:
            begin
                if ((i_reg < n_cur - IW'(2)) && (c_reg > g_rd))
                begin
                    lo_next  = g_rd;
                    i_next   = i_reg + IW'(1);
                    ax_raddr = i_reg + IW'(2);
                end
                else
                begin
                    hi_next    = g_rd;
                    state_next = bli_pkg::B_FRAC;
                end
            end

            // fraction special cases, else start the divide
            bli_pkg::B_FRAC:
            begin
                num = $signed({2'b00, c_reg}) - $signed({2'b00, lo_reg});
                den = $signed({2'b00, hi_reg}) - $signed({2'b00, lo_reg});
                an  = num[C+1] ? C'(1) + (C+1)'(~num) : (C+1)'(num);
                adv = den[C+1] ? C'(1) + (C+1)'(~den) : (C+1)'(den);
                if ((den == 0) || (num == 0) || (num[C+1] != den[C+1]))
                begin
                    fin   = 1'b1;
                    f_fin = '0;
                end
                else if (an >= adv)
                begin
                    fin   = 1'b1;
                    f_fin = ONE;
                end
                else
                begin
                    rem_next   = an;
                    ad_next    = adv;
                    quo_next   = '0;
                    dcnt_next  = DCW'(FRAC_BITS);
                    state_next = bli_pkg::B_DIV;
                end
            end

            // restoring divide, one quotient bit a cycle
            bli_pkg::B_DIV:
            begin
                rem2 = {rem_reg, 1'b0};
                qbit = (rem2 >= {1'b0, ad_reg});
                if (qbit)
                    rem_next = (C+1)'(rem2 - {1'b0, ad_reg});
                else
                    rem_next = rem2[C:0];
                quo_next  = {quo_reg[FW-2:0], qbit};
                dcnt_next = dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                begin
                    fin   = 1'b1;
                    f_fin = {quo_reg[FW-2:0], qbit};
                end
            end

            // corner indexes of the cell
            bli_pkg::B_IDX:
            begin
                rowp       = ie_reg * nt;
                base       = bli_pkg::TAB_AW'(rowp) + bli_pkg::TAB_AW'(it_reg);
                base_next  = base;
                tab_raddr  = base;
                k_next     = 2'd0;
                state_next = bli_pkg::B_TRD;
            end

            // fetch four corners from both tables
            bli_pkg::B_TRD:
            begin
                va_next[k_reg] = bli_pkg::T_W'($signed(ta_rd));
                vb_next[k_reg] = bli_pkg::T_W'($signed(tb_rd));
                tab_raddr = base_reg + (kn[1] ? bli_pkg::TAB_AW'(nt) : '0)
                            + bli_pkg::TAB_AW'(kn[0]);
                if (k_reg == 2'd3)
                begin
                    p_next     = 3'd0;
                    sub_next   = 1'b0;
                    state_next = bli_pkg::B_MAC;
                end
                else
                begin
                    k_next = kn;
                end
            end

            // weighted sums, one product a cycle
            bli_pkg::B_MAC:
            begin
                case (p_reg)
                    3'd0:    opa = sub_reg ? va_reg[1] : va_reg[0];
                    3'd1:    opa = sub_reg ? va_reg[3] : va_reg[2];
                    3'd2:    opa = sub_reg ? vb_reg[1] : vb_reg[0];
                    3'd3:    opa = sub_reg ? vb_reg[3] : vb_reg[2];
                    3'd4:    opa = sub_reg ? t_reg[1] : t_reg[0];
                    default: opa = sub_reg ? t_reg[3] : t_reg[2];
                endcase
                fsel = (p_reg < 3'd4) ? ft_reg : fe_reg;
                wgt  = sub_reg ? fsel : ONE - fsel;
                prod = opa * $signed({1'b0, wgt});
                if (!sub_reg)
                begin
                    acc_next = AW'(prod);
                    sub_next = 1'b1;
                end
                else
                begin
                    sum      = acc_reg + AW'(prod) + HALF;
                    res      = bli_pkg::T_W'(sum >>> FRAC_BITS);
                    sub_next = 1'b0;
                    p_next   = p_reg + 3'd1;
                    case (p_reg)
                        3'd4:
                            ra_next = clamp_q15(res);
                        3'd5:
                        begin
                            rb_next    = clamp_q15(res);
                            state_next = bli_pkg::B_OUT;
                        end
                        default:
                            t_next[p_reg[1:0]] = res;
                    endcase
                end
            end

            // hand the result to the output register once it is free
            bli_pkg::B_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {rb_reg, ra_reg};
                    out_valid_next = 1'b1;
                    state_next     = bli_pkg::B_IDLE;
                end
            end

            default:
                state_next = bli_pkg::B_IDLE;
        endcase

        // end of one axis
        if (fin)
        begin
            if (!ax_reg)
            begin
                fe_next    = f_fin;
                ie_next    = i_reg;
                ax_next    = 1'b1;
                state_next = bli_pkg::B_RD0;
            end
            else
            begin
                ft_next    = f_fin;
                it_next    = i_reg;
                state_next = bli_pkg::B_IDX;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bli_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ce_reg       <= ce_next;
        ct_reg       <= ct_next;
        c_reg        <= c_next;
        g0_reg       <= g0_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        ie_reg       <= ie_next;
        it_reg       <= it_next;
        fe_reg       <= fe_next;
        ft_reg       <= ft_next;
        rem_reg      <= rem_next;
        ad_reg       <= ad_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        base_reg     <= base_next;
        k_reg        <= k_next;
        p_reg        <= p_next;
        sub_reg      <= sub_next;
        acc_reg      <= acc_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        t_reg        <= t_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* sv/bilinear_interp_two_field_core.sv */
// top level of the two field bilinear interpolation core
//
// input stream s_*: each word is a command. axis and table loads write the
// grid and give no result; a query word gives one result word on m_*.
// configuration: cfg_index 0 sets eps_points, 1 sets theta_points; write only
// while idle. both counts reset to 2 and are used saturated to [2, max].
// a query goes through one pop from the queue, then per axis the end point
// reads and clamp, a linear search one point at a time, a fraction check and
// a serial divide when the fraction lies strictly between 0 and 1, then the
// corner table reads, 12 single multiplier steps for the two blends and the
// move to the output register. loads are written as they are popped.
// a two word queue between the decoder and the sequencer keeps s_tready high
// while a query runs, until the queue fills.
// if m_tready stays low the finished result holds in the output register and
// the next query waits before its own result. reset clears the handshake state;
// grid and table contents are undefined until written.
module bilinear_interp_two_field_core #(
    parameter int MAX_AXIS1_POINTS = 16,
    parameter int MAX_AXIS2_POINTS = 16,
    parameter int COORD_BITS       = 16,
    parameter int FRAC_BITS        = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // cmd, load_index, load_value, eps_in, theta_in
    input  logic [63:0]               s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tangential_coeff, normal_coeff
    output logic [31:0]               m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [bli_pkg::CNT_W-1:0] cfg_data
);

    localparam int ITEM_W = bli_pkg::CMD_W + bli_pkg::IDX_W + bli_pkg::VAL_W
                            + 2 * COORD_BITS;

    bli_pkg::cfg_t     cfg_reg, cfg_next;
    logic              q_full;
    logic              q_push;
    logic [ITEM_W-1:0] q_item;
    logic              q_pop;
    logic              q_valid;
    logic [ITEM_W-1:0] q_head;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            if (cfg_index)
                cfg_next.theta_points = cfg_data;
            else
                cfg_next.eps_points = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eps_points   <= bli_pkg::CNT_W'(2);
            cfg_reg.theta_points <= bli_pkg::CNT_W'(2);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    bli_front #(
        .MAX_AXIS1_POINTS (MAX_AXIS1_POINTS),
        .MAX_AXIS2_POINTS (MAX_AXIS2_POINTS),
        .COORD_BITS       (COORD_BITS),
        .ITEM_W           (ITEM_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    bli_queue #(.W(ITEM_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    bli_back #(
        .MAX_AXIS1_POINTS (MAX_AXIS1_POINTS),
        .MAX_AXIS2_POINTS (MAX_AXIS2_POINTS),
        .COORD_BITS       (COORD_BITS),
        .FRAC_BITS        (FRAC_BITS),
        .ITEM_W           (ITEM_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/bli_checker.sv */
// port level checks of the interpolation core and their binding
`include "assert_macros.svh"

module bli_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a waiting result word stays offered and unchanged
    `BLI_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid)
    `BLI_ASSERT(a_out_stable, clk, rst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata))
    // both coefficients stay within [0, 1.0]
    `BLI_ALWAYS(a_coeff_range, clk, rst_n, !m_tvalid || ((m_tdata[15:0] <= 16'd32768) && (m_tdata[31:16] <= 16'd32768)))
    // handshake lines other than m_tready are always driven to known levels
    `BLI_ALWAYS(a_ctrl_known, clk, rst_n, !$isunknown({s_tvalid, s_tready, m_tvalid, cfg_valid, cfg_ready}))

endmodule

bind bilinear_interp_two_field_core bli_checker u_chk (.*);
